@@ src/rti_pkg.sv @@
// Shared widths, register indexes and stage types for the ray/triangle test.
// No dependencies; every other file imports this package.
`default_nettype none

package rti_pkg;

   localparam int W    = 32;            // coordinate width
   localparam int F    = 16;            // fraction bits
   localparam int TOLW = 16;            // tolerance register width
   localparam int IDXW = 3;             // register index width
   localparam int HDW  = W - 1;         // hit_distance width

   localparam int AW = W + 1;           // vertex/point differences
   localparam int PW = 2 * W + 2;       // N.dir
   localparam int DW = 2 * AW + 1;      // N.(origin - vert0)
   localparam int NW = DW + F;          // divider numerator
   localparam int QB = W + F + 3;       // quotient bits kept; larger t saturates the point
   localparam int QL = QB / 2;          // low part of t in the point multiply
   localparam int QH = QB - QL;
   localparam int SW = QB + W + 3;      // hit point before saturation
   localparam int MW = 2 * AW + 1;      // edge cross product component
   localparam int ML = AW;              // low part of m in the dot multiply
   localparam int MH = MW - ML;
   localparam int EW = MW + W + 3;      // edge dot product

   localparam logic [IDXW-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [IDXW-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [IDXW-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [IDXW-1:0] REG_DIR_X    = 3'd3;
   localparam logic [IDXW-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [IDXW-1:0] REG_DIR_Z    = 3'd5;
   localparam logic [IDXW-1:0] REG_TOL      = 3'd6;

   localparam logic signed [SW-1:0] SAT_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_MIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

   typedef struct packed {
      logic [2:0][2:0][W-1:0] v;    // v[vertex][axis]
      logic [2:0][W-1:0]      n;
   } facet_type;

   typedef struct packed {
      facet_type          facet;
      logic               plane_ok;
      logic               ovf;
      logic [PW-1:0]      den;
      logic [PW:0]        rem;
      logic [QB-1:0]      q;
      logic [QB-1:0]      nlo;
   } div_type;

   function automatic logic [W-1:0] sat_coord(input logic signed [SW-1:0] x);
      logic [W-1:0] r;
      if (x > SAT_MAX) r = SAT_MAX[W-1:0];
      else if (x < SAT_MIN) r = SAT_MIN[W-1:0];
      else r = x[W-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/rti_ifs.sv @@
// Channel interfaces: triangle requests, hit responses, register writes.
// Depends on rti_pkg.
`default_nettype none

interface rti_req_if;
   import rti_pkg::*;
   logic valid;
   logic ready;
   logic signed [W-1:0] vert0_x, vert0_y, vert0_z;
   logic signed [W-1:0] vert1_x, vert1_y, vert1_z;
   logic signed [W-1:0] vert2_x, vert2_y, vert2_z;
   logic signed [W-1:0] facet_nx, facet_ny, facet_nz;
   modport source (output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                   vert2_x, vert2_y, vert2_z, facet_nx, facet_ny, facet_nz,
                   input ready);
   modport sink (input valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                 vert2_x, vert2_y, vert2_z, facet_nx, facet_ny, facet_nz,
                 output ready);
endinterface

interface rti_rsp_if;
   import rti_pkg::*;
   logic valid;
   logic ready;
   logic hit;
   logic [HDW-1:0] hit_distance;
   logic signed [W-1:0] hit_x, hit_y, hit_z;
   modport source (output valid, hit, hit_distance, hit_x, hit_y, hit_z, input ready);
   modport sink (input valid, hit, hit_distance, hit_x, hit_y, hit_z, output ready);
endinterface

interface rti_csr_if;
   import rti_pkg::*;
   logic valid;
   logic ready;
   logic [IDXW-1:0] index;
   logic [W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/ray_triangle_intersect.sv @@
// Pipeline: 3 plane stages, 51 divider stages at one quotient bit each, 4
// point/edge stages and an output register between request and response beats.
// Throughput: one triangle per cycle; the whole pipeline holds while a response
// beat is stalled. Reset clears every stage valid bit and loads origin 0,
// dir (0,0,1.0), tolerance 1 lsb.
`default_nettype none

module ray_triangle_intersect (
   input  logic      clock,
   input  logic      reset,
   rti_req_if.sink   req_bus,
   rti_rsp_if.source rsp_bus,
   rti_csr_if.sink   csr_bus
);
   import rti_pkg::*;

   // ---------------- configuration ----------------
   logic signed [W-1:0] origin_ff [3];
   logic signed [W-1:0] dir_ff [3];
   logic [TOLW-1:0]     tol_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         dir_ff[0]    <= '0;
         dir_ff[1]    <= '0;
         dir_ff[2]    <= W'(1) << F;
         tol_ff       <= TOLW'(1);
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_ORIGIN_X: origin_ff[0] <= csr_bus.data;
            REG_ORIGIN_Y: origin_ff[1] <= csr_bus.data;
            REG_ORIGIN_Z: origin_ff[2] <= csr_bus.data;
            REG_DIR_X:    dir_ff[0]    <= csr_bus.data;
            REG_DIR_Y:    dir_ff[1]    <= csr_bus.data;
            REG_DIR_Z:    dir_ff[2]    <= csr_bus.data;
            REG_TOL:      tol_ff       <= csr_bus.data[TOLW-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic rsp_valid_ff;
   logic adv;
   assign adv = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   logic s0_valid_ff, s1_valid_ff, s2_valid_ff;
   logic [QB-1:0] dv_valid_ff;
   logic s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         dv_valid_ff  <= '0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff  <= req_bus.valid;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         dv_valid_ff  <= {dv_valid_ff[QB-2:0], s2_valid_ff};
         s3_valid_ff  <= dv_valid_ff[QB-1];
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         rsp_valid_ff <= s6_valid_ff;
      end
   end

   // ---------------- S0: capture ----------------
   facet_type s0_facet_ff;
   facet_type req_facet;

   always_comb begin
      req_facet.v[0][0] = req_bus.vert0_x;
      req_facet.v[0][1] = req_bus.vert0_y;
      req_facet.v[0][2] = req_bus.vert0_z;
      req_facet.v[1][0] = req_bus.vert1_x;
      req_facet.v[1][1] = req_bus.vert1_y;
      req_facet.v[1][2] = req_bus.vert1_z;
      req_facet.v[2][0] = req_bus.vert2_x;
      req_facet.v[2][1] = req_bus.vert2_y;
      req_facet.v[2][2] = req_bus.vert2_z;
      req_facet.n[0]    = req_bus.facet_nx;
      req_facet.n[1]    = req_bus.facet_ny;
      req_facet.n[2]    = req_bus.facet_nz;
   end

   always_ff @(posedge clock) begin
      if (adv) s0_facet_ff <= req_facet;
   end

   // ---------------- S1: N.dir and N.(origin - vert0) products ----------------
   facet_type s1_facet_ff;
   logic signed [2*W-1:0]  s1_nd_ff [3];
   logic signed [W+AW-1:0] s1_nf_ff [3];
   logic signed [2*W-1:0]  s1_nd_in [3];
   logic signed [W+AW-1:0] s1_nf_in [3];
   logic signed [AW-1:0]   s1_diff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_diff[i]  = AW'(origin_ff[i]) - AW'($signed(s0_facet_ff.v[0][i]));
         s1_nd_in[i] = $signed(s0_facet_ff.n[i]) * dir_ff[i];
         s1_nf_in[i] = $signed(s0_facet_ff.n[i]) * s1_diff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_facet_ff <= s0_facet_ff;
         s1_nd_ff    <= s1_nd_in;
         s1_nf_ff    <= s1_nf_in;
      end
   end

   // ---------------- S2: plane test, divider operands ----------------
   logic signed [PW-1:0] d1;
   logic signed [DW-1:0] plane_dist;
   logic signed [PW-1:0] tol1;
   logic [NW-1:0]        num;
   logic [PW-1:0]        den;
   div_type              s2_div_in, s2_div_ff;

   always_comb begin
      d1         = PW'(s1_nd_ff[0]) + PW'(s1_nd_ff[1]) + PW'(s1_nd_ff[2]);
      plane_dist = DW'(s1_nf_ff[0]) + DW'(s1_nf_ff[1]) + DW'(s1_nf_ff[2]);
      tol1       = -$signed(PW'({tol_ff, {F{1'b0}}}));
      num        = {plane_dist, {F{1'b0}}};
      den        = -d1;
      s2_div_in.facet    = s1_facet_ff;
      s2_div_in.plane_ok = d1[PW-1] && (d1 <= tol1) && !plane_dist[DW-1];
      // quotient that does not fit in QB bits saturates the result anyway
      s2_div_in.ovf      = (PW+QB)'(num) >= {den, {QB{1'b0}}};
      s2_div_in.den      = den;
      s2_div_in.rem      = (PW+1)'(num[NW-1:QB]);
      s2_div_in.q        = '0;
      s2_div_in.nlo      = num[QB-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) s2_div_ff <= s2_div_in;
   end

   // ---------------- divider: one restoring step per stage ----------------
   div_type dv_ff [QB];
   div_type dv_src [QB];
   div_type dv_in [QB];

   assign dv_src[0] = s2_div_ff;

   for (genvar j = 0; j < QB; j++) begin : g_div
      logic [PW:0] r2;
      if (j > 0) begin : g_link
         assign dv_src[j] = dv_ff[j-1];
      end
      always_comb begin
         r2       = {dv_src[j].rem[PW-1:0], dv_src[j].nlo[QB-1-j]};
         dv_in[j] = dv_src[j];
         if (r2 >= {1'b0, dv_src[j].den}) begin
            dv_in[j].rem        = r2 - {1'b0, dv_src[j].den};
            dv_in[j].q[QB-1-j]  = 1'b1;
         end else begin
            dv_in[j].rem = r2;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) dv_ff[j] <= dv_in[j];
      end
   end

   // ---------------- S3: t * dir partial products ----------------
   logic [QB-1:0]            t_q;
   facet_type                s3_facet_ff;
   logic                     s3_plane_ok_ff;
   logic [HDW-1:0]           s3_hd_ff, s3_hd_in;
   logic signed [QH+W:0]     s3_ph_ff [3], s3_ph_in [3];
   logic signed [QL+W:0]     s3_pl_ff [3], s3_pl_in [3];

   always_comb begin
      t_q = dv_ff[QB-1].ovf ? {QB{1'b1}} : dv_ff[QB-1].q;
      if (!dv_ff[QB-1].plane_ok) s3_hd_in = '0;
      else if (|t_q[QB-1:HDW]) s3_hd_in = {HDW{1'b1}};
      else s3_hd_in = t_q[HDW-1:0];
      for (int i = 0; i < 3; i++) begin
         s3_ph_in[i] = $signed({1'b0, t_q[QB-1:QL]}) * dir_ff[i];
         s3_pl_in[i] = $signed({1'b0, t_q[QL-1:0]}) * dir_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_facet_ff    <= dv_ff[QB-1].facet;
         s3_plane_ok_ff <= dv_ff[QB-1].plane_ok;
         s3_hd_ff       <= s3_hd_in;
         s3_ph_ff       <= s3_ph_in;
         s3_pl_ff       <= s3_pl_in;
      end
   end

   // ---------------- S4: hit point, rounded and saturated ----------------
   facet_type            s4_facet_ff;
   logic                 s4_plane_ok_ff;
   logic [HDW-1:0]       s4_hd_ff;
   logic [W-1:0]         s4_p_ff [3], s4_p_in [3];
   logic signed [SW-1:0] s4_step [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_step[i] = ((SW'(s3_ph_ff[i]) <<< QL) + SW'(s3_pl_ff[i])
                       + (SW'(1) <<< (F-1))) >>> F;
         s4_p_in[i] = sat_coord(s4_step[i] + SW'(origin_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_facet_ff    <= s3_facet_ff;
         s4_plane_ok_ff <= s3_plane_ok_ff;
         s4_hd_ff       <= s3_hd_ff;
         s4_p_ff        <= s4_p_in;
      end
   end

   // ---------------- S5: edge cross product terms ----------------
   facet_type              s5_facet_ff;
   logic                   s5_plane_ok_ff;
   logic [HDW-1:0]         s5_hd_ff;
   logic [W-1:0]           s5_p_ff [3];
   logic signed [2*AW-1:0] s5_pa_ff [3][3], s5_pa_in [3][3];
   logic signed [2*AW-1:0] s5_pb_ff [3][3], s5_pb_in [3][3];
   logic signed [AW-1:0]   ea [3][3];
   logic signed [AW-1:0]   ee [3][3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            ea[k][i] = AW'($signed(s4_facet_ff.v[k][i])) - AW'($signed(s4_p_ff[i]));
            ee[k][i] = AW'($signed(s4_facet_ff.v[(k+1)%3][i]))
                       - AW'($signed(s4_facet_ff.v[k][i]));
         end
         // m[c] = a[c+1]*e[c+2] - a[c+2]*e[c+1]
         for (int c = 0; c < 3; c++) begin
            s5_pa_in[k][c] = ea[k][(c+1)%3] * ee[k][(c+2)%3];
            s5_pb_in[k][c] = ea[k][(c+2)%3] * ee[k][(c+1)%3];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_facet_ff    <= s4_facet_ff;
         s5_plane_ok_ff <= s4_plane_ok_ff;
         s5_hd_ff       <= s4_hd_ff;
         s5_p_ff        <= s4_p_ff;
         s5_pa_ff       <= s5_pa_in;
         s5_pb_ff       <= s5_pb_in;
      end
   end

   // ---------------- S6: m . n partial products ----------------
   logic                   s6_plane_ok_ff;
   logic [HDW-1:0]         s6_hd_ff;
   logic [W-1:0]           s6_p_ff [3];
   logic signed [MH+W-1:0] s6_qh_ff [3][3], s6_qh_in [3][3];
   logic signed [ML+W:0]   s6_ql_ff [3][3], s6_ql_in [3][3];
   logic signed [MW-1:0]   mc [3][3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int c = 0; c < 3; c++) begin
            mc[k][c]       = MW'(s5_pa_ff[k][c]) - MW'(s5_pb_ff[k][c]);
            s6_qh_in[k][c] = $signed(mc[k][c][MW-1:ML]) * $signed(s5_facet_ff.n[c]);
            s6_ql_in[k][c] = $signed({1'b0, mc[k][c][ML-1:0]}) * $signed(s5_facet_ff.n[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_plane_ok_ff <= s5_plane_ok_ff;
         s6_hd_ff       <= s5_hd_ff;
         s6_p_ff        <= s5_p_ff;
         s6_qh_ff       <= s6_qh_in;
         s6_ql_ff       <= s6_ql_in;
      end
   end

   // ---------------- output register ----------------
   logic signed [EW-1:0] edge_dot [3];
   logic signed [EW-1:0] tol2;
   logic [2:0]           edge_ok;
   logic                 hit_in;
   logic                 rsp_hit_ff;
   logic [HDW-1:0]       rsp_hd_ff;
   logic [W-1:0]         rsp_p_ff [3];

   always_comb begin
      tol2 = -$signed(EW'({tol_ff, {(2*F){1'b0}}}));
      for (int k = 0; k < 3; k++) begin
         edge_dot[k] = '0;
         for (int c = 0; c < 3; c++) begin
            edge_dot[k] = edge_dot[k] + (EW'(s6_qh_ff[k][c]) <<< ML) + EW'(s6_ql_ff[k][c]);
         end
         edge_ok[k] = !(edge_dot[k] < tol2);
      end
      hit_in = s6_plane_ok_ff && (&edge_ok);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff <= hit_in;
         rsp_hd_ff  <= s6_hd_ff;
         for (int i = 0; i < 3; i++) rsp_p_ff[i] <= hit_in ? s6_p_ff[i] : '0;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.hit          = rsp_hit_ff;
   assign rsp_bus.hit_distance = rsp_hd_ff;
   assign rsp_bus.hit_x        = rsp_p_ff[0];
   assign rsp_bus.hit_y        = rsp_p_ff[1];
   assign rsp_bus.hit_z        = rsp_p_ff[2];

endmodule

`default_nettype wire

@@ src/rti_checker.sv @@
// Port-level checks for ray_triangle_intersect, attached by bind.
// Depends on rti_pkg and the top level's interface ports.
`default_nettype none

module rti_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_hit,
   input logic [rti_pkg::HDW-1:0]   rsp_hit_distance,
   input logic [rti_pkg::W-1:0]     rsp_hit_x,
   input logic [rti_pkg::W-1:0]     rsp_hit_y,
   input logic [rti_pkg::W-1:0]     rsp_hit_z
);
   import rti_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hit) && $stable(rsp_hit_distance)
                                  && $stable(rsp_hit_x))
      else $error("stalled response changed");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_x == '0 && rsp_hit_y == '0 && rsp_hit_z == '0)
      else $error("miss with nonzero hit point");

   a_stall_only: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request side stalled without response backpressure");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_hit          (rsp_bus.hit),
   .rsp_hit_distance (rsp_bus.hit_distance),
   .rsp_hit_x        (rsp_bus.hit_x),
   .rsp_hit_y        (rsp_bus.hit_y),
   .rsp_hit_z        (rsp_bus.hit_z)
);

`default_nettype wire
